@@ rtl/pbm_pkg.sv @@
// Shared types and constants for the power state and battery monitor.
package pbm_pkg;

    localparam int unsigned AddrWidth = 5;
    localparam int unsigned DataWidth = 32;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_FULL_MV        = 3'd0;
    localparam logic [2:0] REG_EMPTY_MV       = 3'd1;
    localparam logic [2:0] REG_LOW_THRESHOLD  = 3'd2;
    localparam logic [2:0] REG_IDLE_TIMEOUT   = 3'd3;
    localparam logic [2:0] REG_SLEEP_TIMEOUT  = 3'd4;
    localparam logic [2:0] REG_LONG_PRESS     = 3'd5;
    localparam logic [2:0] REG_BATT_INTERVAL  = 3'd6;

    // Reset values of the registers
    localparam logic [12:0] FULL_MV_RST        = 13'd4200;
    localparam logic [12:0] EMPTY_MV_RST       = 13'd3300;
    localparam logic [6:0]  LOW_THRESHOLD_RST  = 7'd20;
    localparam logic [31:0] IDLE_TIMEOUT_RST   = 32'd300000;
    localparam logic [31:0] SLEEP_TIMEOUT_RST  = 32'd600000;
    localparam logic [31:0] LONG_PRESS_RST     = 32'd3000;
    localparam logic [31:0] BATT_INTERVAL_RST  = 32'd10000;

    // ADC full scale in millivolts; the ADC is 12 bits, so divide by 4096 with a shift
    localparam logic [12:0] ADC_FULL_SCALE_MV  = 13'd6600;
    localparam logic [6:0]  LEVEL_FULL         = 7'd100;
    localparam logic [6:0]  LEVEL_EMPTY        = 7'd0;

    typedef enum logic [2:0] {
        MODE_INIT     = 3'd0,
        MODE_ACTIVE   = 3'd1,
        MODE_IDLE     = 3'd2,
        MODE_SLEEP    = 3'd3,
        MODE_SHUTDOWN = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_ACTIVITY = 2'd1,
        OP_BUTTON   = 2'd2,
        OP_SAMPLE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_WAIT   = 3'd0,
        ST_MULT   = 3'd1,
        ST_RANGE  = 3'd2,
        ST_DIV    = 3'd3,
        ST_FINISH = 3'd4
    } exec_state_t;

    typedef struct packed {
        op_t         op;
        logic [11:0] adc;
        logic        charging;
    } item_t;

    typedef struct packed {
        logic [12:0] full_mv;
        logic [12:0] empty_mv;
        logic [6:0]  low_threshold_pct;
        logic [31:0] idle_timeout_ms;
        logic [31:0] sleep_timeout_ms;
        logic [31:0] long_press_ms;
        logic [31:0] battery_interval_ms;
    } cfg_t;

endpackage

@@ rtl/pbm_regs.sv @@
// Configuration register file behind the APB-style port.
module pbm_regs
    import pbm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [DataWidth-1:0] pwdata,
    output logic [DataWidth-1:0] prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[AddrWidth-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_mv             <= FULL_MV_RST;
            cfg_reg.empty_mv            <= EMPTY_MV_RST;
            cfg_reg.low_threshold_pct   <= LOW_THRESHOLD_RST;
            cfg_reg.idle_timeout_ms     <= IDLE_TIMEOUT_RST;
            cfg_reg.sleep_timeout_ms    <= SLEEP_TIMEOUT_RST;
            cfg_reg.long_press_ms       <= LONG_PRESS_RST;
            cfg_reg.battery_interval_ms <= BATT_INTERVAL_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_FULL_MV:       cfg_reg.full_mv             <= pwdata[12:0];
                REG_EMPTY_MV:      cfg_reg.empty_mv            <= pwdata[12:0];
                REG_LOW_THRESHOLD: cfg_reg.low_threshold_pct   <= pwdata[6:0];
                REG_IDLE_TIMEOUT:  cfg_reg.idle_timeout_ms     <= pwdata;
                REG_SLEEP_TIMEOUT: cfg_reg.sleep_timeout_ms    <= pwdata;
                REG_LONG_PRESS:    cfg_reg.long_press_ms       <= pwdata;
                REG_BATT_INTERVAL: cfg_reg.battery_interval_ms <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FULL_MV:       prdata = {19'd0, cfg_reg.full_mv};
            REG_EMPTY_MV:      prdata = {19'd0, cfg_reg.empty_mv};
            REG_LOW_THRESHOLD: prdata = {25'd0, cfg_reg.low_threshold_pct};
            REG_IDLE_TIMEOUT:  prdata = cfg_reg.idle_timeout_ms;
            REG_SLEEP_TIMEOUT: prdata = cfg_reg.sleep_timeout_ms;
            REG_LONG_PRESS:    prdata = cfg_reg.long_press_ms;
            REG_BATT_INTERVAL: prdata = cfg_reg.battery_interval_ms;
            default:           prdata = '0;
        endcase
    end

endmodule

@@ rtl/pbm_front.sv @@
// Front end: accept input words, classify the command and queue them.
module pbm_front
    import pbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [11:0] adc_sample,
    input  logic        charger_active,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    item_t      classified;

    always_comb
    begin
        case (cmd)
            OP_TICK:     classified.op = OP_TICK;
            OP_ACTIVITY: classified.op = OP_ACTIVITY;
            OP_BUTTON:   classified.op = OP_BUTTON;
            default:     classified.op = OP_SAMPLE;
        endcase
        classified.adc      = adc_sample;
        classified.charging = charger_active;
    end

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= classified;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/pbm_back.sv @@
// Back end: power state machine, battery gauge with iterative divider, result word.
module pbm_back
    import pbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  power_mode,
    output logic [12:0] battery_mv,
    output logic [6:0]  level_pct,
    output logic        is_charging_now,
    output logic        battery_low,
    output logic [9:0]  minutes_left,
    output logic        status_refreshed
);

    exec_state_t state_reg;
    exec_state_t state_next;

    mode_t       mode_reg;
    mode_t       mode_next;
    logic [31:0] clock_reg;
    logic [31:0] idle_cnt_reg;
    logic [31:0] press_start_reg;
    logic        press_pending_reg;
    logic [31:0] refresh_time_reg;
    logic [12:0] cached_mv_reg;
    logic [6:0]  cached_level_reg;
    logic        cached_charging_reg;
    logic        cached_low_reg;
    logic [9:0]  cached_minutes_reg;
    logic        refreshed_reg;
    logic        out_valid_reg;

    logic [11:0] adc_reg;
    logic        chg_reg;
    logic [12:0] mv_reg;
    logic [19:0] rem_reg;
    logic [12:0] den_reg;
    logic [6:0]  quo_reg;
    logic [2:0]  cnt_reg;

    logic        out_free;
    logic        sample_go;
    logic        saturated;
    logic        load_out;
    logic [31:0] clock_inc;
    logic [31:0] idle_inc;
    logic [31:0] press_dur;
    logic [31:0] refresh_age;
    logic [24:0] mv_prod;
    logic [12:0] mv_diff;
    logic [19:0] div_num;
    logic [19:0] den_shift;
    logic [9:0]  minutes_calc;

    assign out_free    = !out_valid_reg || out_ready;
    assign clock_inc   = clock_reg + 32'd1;
    assign idle_inc    = idle_cnt_reg + 32'd1;
    assign press_dur   = clock_reg - press_start_reg;
    assign refresh_age = clock_reg - refresh_time_reg;
    assign sample_go   = (q_item.op == OP_SAMPLE) && (mode_reg != MODE_SHUTDOWN)
                         && ((mode_reg == MODE_INIT)
                             || (refresh_age >= cfg.battery_interval_ms));
    assign saturated   = (mv_reg >= cfg.full_mv) || (mv_reg <= cfg.empty_mv);
    assign mv_prod     = {13'd0, adc_reg} * {12'd0, ADC_FULL_SCALE_MV};
    assign mv_diff     = mv_reg - cfg.empty_mv;
    // (mv - empty) * 100 as shifts and adds
    assign div_num     = ({7'd0, mv_diff} << 6) + ({7'd0, mv_diff} << 5)
                         + ({7'd0, mv_diff} << 2);
    assign den_shift   = {7'd0, den_reg} << cnt_reg;
    // level * 500 / 100 * 60 / 50 reduces to level * 6
    assign minutes_calc = ({3'd0, quo_reg} << 2) + ({3'd0, quo_reg} << 1);

    // Mode update for events handled straight from the wait state
    always_comb
    begin
        mode_next = mode_reg;
        if (mode_reg != MODE_SHUTDOWN)
        begin
            case (q_item.op)
                OP_TICK:
                begin
                    if ((idle_inc > cfg.idle_timeout_ms) && (mode_reg == MODE_ACTIVE))
                    begin
                        mode_next = MODE_IDLE;
                        if (idle_inc > cfg.sleep_timeout_ms)
                        begin
                            mode_next = MODE_SLEEP;
                        end
                    end
                    else if ((idle_inc > cfg.sleep_timeout_ms) && (mode_reg == MODE_IDLE))
                    begin
                        mode_next = MODE_SLEEP;
                    end
                end
                OP_BUTTON:
                begin
                    if (press_pending_reg)
                    begin
                        if (press_dur > cfg.long_press_ms)
                        begin
                            mode_next = MODE_SHUTDOWN;
                        end
                        else if (mode_reg == MODE_SLEEP)
                        begin
                            mode_next = MODE_ACTIVE;
                        end
                        else
                        begin
                            mode_next = MODE_SLEEP;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_WAIT:
            begin
                if (q_valid && out_free && sample_go)
                begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:   state_next = ST_RANGE;
            ST_RANGE:  state_next = saturated ? ST_FINISH : ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == 3'd0)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_WAIT;
                end
            end
            default:   state_next = ST_WAIT;
        endcase
    end

    // Control outputs
    always_comb
    begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_WAIT:
            begin
                if (q_valid && out_free)
                begin
                    q_pop    = 1'b1;
                    load_out = !sample_go;
                end
            end
            ST_FINISH: load_out = out_free;
            default:   ;
        endcase
    end

    // Battery datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_WAIT:
            begin
                adc_reg <= q_item.adc;
                chg_reg <= q_item.charging;
            end
            ST_MULT:   mv_reg <= mv_prod[24:12];
            ST_RANGE:
            begin
                rem_reg <= div_num;
                den_reg <= cfg.full_mv - cfg.empty_mv;
                cnt_reg <= 3'd6;
                if (mv_reg >= cfg.full_mv)
                begin
                    quo_reg <= LEVEL_FULL;
                end
                else
                begin
                    quo_reg <= LEVEL_EMPTY;
                end
            end
            ST_DIV:
            begin
                // One restoring step per cycle, quotient bit by bit from the top
                if (rem_reg >= den_shift)
                begin
                    rem_reg          <= rem_reg - den_shift;
                    quo_reg[cnt_reg] <= 1'b1;
                end
                cnt_reg <= cnt_reg - 3'd1;
            end
            default:   ;
        endcase
    end

    // Architectural state and the result word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_WAIT;
            mode_reg            <= MODE_INIT;
            clock_reg           <= '0;
            idle_cnt_reg        <= '0;
            press_start_reg     <= '0;
            press_pending_reg   <= 1'b0;
            refresh_time_reg    <= '0;
            cached_mv_reg       <= '0;
            cached_level_reg    <= '0;
            cached_charging_reg <= 1'b0;
            cached_low_reg      <= 1'b0;
            cached_minutes_reg  <= '0;
            refreshed_reg       <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if ((state_reg == ST_WAIT) && load_out)
            begin
                refreshed_reg <= 1'b0;
                mode_reg      <= mode_next;
                if (mode_reg != MODE_SHUTDOWN)
                begin
                    case (q_item.op)
                        OP_TICK:
                        begin
                            clock_reg    <= clock_inc;
                            idle_cnt_reg <= idle_inc;
                        end
                        OP_ACTIVITY: idle_cnt_reg <= '0;
                        OP_BUTTON:
                        begin
                            if (!press_pending_reg)
                            begin
                                press_start_reg <= clock_reg;
                            end
                            press_pending_reg <= !press_pending_reg;
                        end
                        default: ;
                    endcase
                end
            end

            if ((state_reg == ST_FINISH) && load_out)
            begin
                refreshed_reg       <= 1'b1;
                cached_mv_reg       <= mv_reg;
                cached_level_reg    <= quo_reg;
                cached_charging_reg <= chg_reg;
                cached_low_reg      <= (quo_reg < cfg.low_threshold_pct);
                cached_minutes_reg  <= chg_reg ? 10'd0 : minutes_calc;
                refresh_time_reg    <= clock_reg;
                if (mode_reg == MODE_INIT)
                begin
                    mode_reg <= MODE_IDLE;
                end
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign power_mode       = mode_reg;
    assign battery_mv       = cached_mv_reg;
    assign level_pct        = cached_level_reg;
    assign is_charging_now  = cached_charging_reg;
    assign battery_low      = cached_low_reg;
    assign minutes_left     = cached_minutes_reg;
    assign status_refreshed = refreshed_reg;

endmodule

@@ rtl/power_state_and_battery_monitor.sv @@
// Power state controller with battery gauge: top level.
//
// Input channel (in_valid/in_ready) carries one event word: cmd selects a 1 ms
// tick, a user activity mark, a power-button edge or a battery ADC sample with
// the charger flag. Every accepted word yields exactly one result word on the
// output channel (out_valid/out_ready): power mode plus cached battery status.
// A two-entry queue sits between the front end and the execution unit, so the
// input side keeps taking words while a result waits on a stalled receiver.
// Ticks, activity marks, button edges and rejected samples give their result
// in the cycle after they leave the queue; an accepted sample passes the
// shared multiply stage and the range check and, unless the voltage is clamped
// at full or empty, the 7-step restoring divider for the level.
// Simple events go through at one word per cycle while out_ready stays high;
// a sample runs to its result before the next word leaves the queue.
// While out_ready is low the result word holds and the execution unit waits;
// the queue fills and then in_ready drops. Reset clears the mode to init,
// the millisecond clock, the press/activity tracking and the cached status, and
// loads the register defaults. Write configuration only while the block is idle.
module power_state_and_battery_monitor
    import pbm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [DataWidth-1:0] pwdata,
    output logic [DataWidth-1:0] prdata,
    output logic                 pready,
    // event words
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           cmd,
    input  logic [11:0]          adc_sample,
    input  logic                 charger_active,
    // result words
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           power_mode,
    output logic [12:0]          battery_mv,
    output logic [6:0]           level_pct,
    output logic                 is_charging_now,
    output logic                 battery_low,
    output logic [9:0]           minutes_left,
    output logic                 status_refreshed
);

    cfg_t  cfg;
    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    // Hold the register set; writes land on the access cycle
    pbm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Accept and classify events, queue them for execution
    pbm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .adc_sample     (adc_sample),
        .charger_active (charger_active),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop)
    );

    // Advance the power state, refresh the battery status, drive the result
    pbm_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .power_mode       (power_mode),
        .battery_mv       (battery_mv),
        .level_pct        (level_pct),
        .is_charging_now  (is_charging_now),
        .battery_low      (battery_low),
        .minutes_left     (minutes_left),
        .status_refreshed (status_refreshed)
    );

endmodule
